[src/ppg_pulse_and_oxygen_estimator_unit_defines.svh]
// Assertion macros shared by the estimator RTL.
`ifndef PPG_PULSE_AND_OXYGEN_ESTIMATOR_UNIT_DEFINES_SVH
`define PPG_PULSE_AND_OXYGEN_ESTIMATOR_UNIT_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define PPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/ppg_pkg.sv]
// ----------------------------------------------------------------------------
// PPG estimator package
// Shared constants, types and register indexes.
// ----------------------------------------------------------------------------
package ppg_pkg;
  localparam int SampleBitsDef   = 18;
  localparam int FractionBitsDef = 8;
  localparam int AddrBits        = 5;

  typedef enum logic [2:0] {
    REG_DC_ALPHA  = 3'd0,
    REG_INTERVAL  = 3'd1,
    REG_FINGER    = 3'd2,
    REG_MIN_BEAT  = 3'd3,
    REG_MAX_BEAT  = 3'd4,
    REG_TIMEOUT   = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_BASE, ST_THR, ST_PEAK, ST_RDIV, ST_RATE,
    ST_T1DIV, ST_T2DIV, ST_OXY, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic base;
    logic thr;
    logic peak;
    logic rdiv_start;
    logic rate;
    logic t1_start;
    logic t2_start;
    logic oxy;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic too_soon;
    logic no_finger;
    logic div_busy;
    logic need_rate;
  } ctrl_sts_t;
endpackage

[src/ppg_stream_if.sv]
// ----------------------------------------------------------------------------
// PPG stream interfaces
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface ppg_in_if #(parameter int SampleBits = 18) ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] ir_sample;
  logic [SampleBits-1:0] red_sample;
  logic [31:0]           time_ms;
  modport source (output valid, ir_sample, red_sample, time_ms, input ready);
  modport sink (input valid, ir_sample, red_sample, time_ms, output ready);
endinterface

interface ppg_out_if ();
  logic               valid;
  logic               ready;
  logic               sample_used;
  logic               finger_present;
  logic               beat;
  logic [15:0]        heart_rate;
  logic [15:0]        beat_interval_ms;
  logic [14:0]        oxygen_level;
  logic [25:0]        dc_level;
  logic signed [26:0] ac_level;
  modport source (output valid, sample_used, finger_present, beat, heart_rate,
                  beat_interval_ms, oxygen_level, dc_level, ac_level, input ready);
  modport sink (input valid, sample_used, finger_present, beat, heart_rate,
                beat_interval_ms, oxygen_level, dc_level, ac_level, output ready);
endinterface

[src/ppg_divider.sv]
// ----------------------------------------------------------------------------
// PPG serial divider
// Restoring divider, one quotient bit per cycle, with a truncated quotient.
// ----------------------------------------------------------------------------
module ppg_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [47:0] den_i,
  output logic        busy_o,
  output logic [47:0] quo_o
);
  logic [47:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q, quo_q[47]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = 48'(shifted - {1'b0, den_q});
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted[47:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

[src/ppg_ctrl.sv]
// ----------------------------------------------------------------------------
// PPG controller
// Sequences the datapath through one sample word.
// ----------------------------------------------------------------------------
module ppg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  input  ppg_pkg::ctrl_sts_t sts_i,
  output ppg_pkg::ctrl_cmd_t cmd_o
);
  import ppg_pkg::*;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.too_soon || sts_i.no_finger) state_d = ST_OUT;
        else state_d = ST_BASE;
      end
      ST_BASE:  state_d = ST_THR;
      ST_THR:   state_d = ST_PEAK;
      ST_PEAK:  state_d = sts_i.need_rate ? ST_RDIV : ST_T1DIV;
      ST_RDIV:  if (!sts_i.div_busy) state_d = ST_RATE;
      ST_RATE:  state_d = ST_T1DIV;
      ST_T1DIV: if (!sts_i.div_busy) state_d = ST_T2DIV;
      ST_T2DIV: if (!sts_i.div_busy) state_d = ST_OXY;
      ST_OXY:   state_d = ST_OUT;
      ST_OUT:   if (!out_busy_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // The divider start pulses fire on entry to a wait state.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE:  cmd_o.load = in_valid_i;
      ST_CHECK: cmd_o.check = 1'b1;
      ST_BASE:  cmd_o.base = 1'b1;
      ST_THR:   cmd_o.thr = 1'b1;
      ST_PEAK: begin
        cmd_o.peak = 1'b1;
        cmd_o.rdiv_start = sts_i.need_rate;
        cmd_o.t1_start = !sts_i.need_rate;
      end
      ST_RATE: begin
        cmd_o.rate = 1'b1;
        cmd_o.t1_start = 1'b1;
      end
      ST_T1DIV: cmd_o.t2_start = !sts_i.div_busy;
      ST_OXY:   cmd_o.oxy = 1'b1;
      ST_OUT:   cmd_o.out_load = !out_busy_i;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule

[src/ppg_datapath.sv]
// ----------------------------------------------------------------------------
// PPG datapath
// Filters, peak detection, rate and SpO2 arithmetic and the result register.
// ----------------------------------------------------------------------------
module ppg_datapath #(
  parameter int SampleBits   = ppg_pkg::SampleBitsDef,
  parameter int FractionBits = ppg_pkg::FractionBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppg_pkg::ctrl_cmd_t cmd_i,
  output ppg_pkg::ctrl_sts_t sts_o,
  input  logic [SampleBits-1:0] ir_i,
  input  logic [SampleBits-1:0] red_i,
  input  logic [31:0]        time_i,
  input  logic [15:0]        dc_alpha_i,
  input  logic [15:0]        interval_i,
  input  logic [17:0]        finger_i,
  input  logic [15:0]        min_beat_i,
  input  logic [15:0]        max_beat_i,
  input  logic [15:0]        timeout_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_used_o,
  output logic               finger_present_o,
  output logic               beat_o,
  output logic [15:0]        heart_rate_o,
  output logic [15:0]        beat_interval_ms_o,
  output logic [14:0]        oxygen_level_o,
  output logic [25:0]        dc_level_o,
  output logic signed [26:0] ac_level_o
);
  import ppg_pkg::*;
  localparam int XW = SampleBits + FractionBits;
  localparam int AW = XW + 1;
  localparam logic [47:0] OneQ = 48'(1) << FractionBits;

  logic [SampleBits-1:0] ir_q, red_q;
  logic [31:0] now_q, last_acc_q, last_peak_q;
  logic peak_valid_q, used_q, finger_q, beat_q;
  logic [XW-1:0] base_q, thr_q;
  logic signed [AW-1:0] ac_q, prev_q, older_q;
  logic [15:0] rate_q, ivl_q;
  logic [14:0] oxy_q;
  logic [47:0] t1_q;
  logic t2_neg_q;
  logic ovalid_q;

  logic div_start, div_busy;
  logic [47:0] div_num, div_den, div_quo;

  ppg_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  logic [XW-1:0] x, b0;
  logic [XW+17:0] base_sum;
  logic [AW-1:0] amp;
  logic [XW+17:0] thr_sum;
  logic [XW+16:0] thr_scaled;
  logic is_peak;
  logic tmo_hit;
  logic [31:0] pdiff;
  logic [47:0] mag, den2, red_num;
  logic signed [49:0] raw;
  logic [47:0] rate_cur;
  logic [33:0] rate_sum;
  logic [31:0] oxy_sum;
  logic signed [49:0] t2v;

  always_comb begin
    x = XW'(ir_q) << FractionBits;
    b0 = (48'(base_q) < OneQ) ? x : base_q;
    base_sum = (XW+18)'(((XW+18)'(17'h10000 - 17'(dc_alpha_i)) * b0)
             + ((XW+18)'(dc_alpha_i) * x) + 32768);
    amp = ac_q[AW-1] ? AW'(-ac_q) : AW'(ac_q);
    thr_sum = (XW+18)'(((XW+18)'(64225) * thr_q) + ((XW+18)'(1311) * amp) + 32768);
    thr_scaled = (XW+17)'(thr_q) * (XW+17)'(55706);
    is_peak = (prev_q > older_q) && (prev_q > ac_q) && !prev_q[AW-1]
            && ({prev_q[AW-2:0], 16'h0} > 65'(thr_scaled));
    pdiff = now_q - last_peak_q;
    // At the SpO2 step the peak time is already settled, so this is the timeout.
    tmo_hit = peak_valid_q && (pdiff > 32'(timeout_i));
    mag = ac_q[AW-1] ? 48'(-ac_q) : 48'(ac_q);
    den2 = (tmo_hit ? 48'd0 : (48'(thr_q) * 48'd10)) + OneQ;
    red_num = (48'(red_q) * 48'd3) << FractionBits;
    rate_cur = (div_quo > 48'd65535) ? 48'd65535 : div_quo;
    rate_sum = 34'((34'(58982) * rate_q) + (34'(6554) * rate_cur[15:0]) + 32768);
    t2v = t2_neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    raw = $signed(50'(99 * OneQ)) - $signed({2'b00, t1_q}) + t2v;
    if (raw < $signed(50'(90 * OneQ))) raw = 50'(90 * OneQ);
    if (raw > $signed(50'(100 * OneQ))) raw = 50'(100 * OneQ);
    oxy_sum = 32'((32'(62259) * oxy_q) + (32'(3277) * raw[14:0]) + 32768);
  end

  always_comb begin
    div_start = cmd_i.rdiv_start | cmd_i.t1_start | cmd_i.t2_start;
    div_num = '0;
    div_den = 48'd1;
    if (cmd_i.rdiv_start) begin
      div_num = (48'd60000 * OneQ) + 48'(pdiff >> 1);
      div_den = 48'(pdiff);
    end else if (cmd_i.t1_start) begin
      div_num = red_num + 48'(ir_q) * 48'd10;
      div_den = 48'(ir_q) * 48'd20;
    end else if (cmd_i.t2_start) begin
      div_num = ((mag * 48'd5) << FractionBits) + (den2 >> 1);
      div_den = den2;
    end
  end

  assign sts_o.too_soon  = (now_q - last_acc_q) < 32'(interval_i);
  assign sts_o.no_finger = 18'(ir_q) <= finger_i;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.need_rate = is_peak && peak_valid_q && (pdiff > 32'(min_beat_i))
                         && (pdiff < 32'(max_beat_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; thr_q <= '0; prev_q <= '0; older_q <= '0;
      last_peak_q <= '0; last_acc_q <= '0; peak_valid_q <= 1'b0;
      rate_q <= '0; ivl_q <= '0; oxy_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.check) begin
        if (!sts_o.too_soon) begin
          last_acc_q <= now_q;
          if (sts_o.no_finger) begin
            base_q <= '0; thr_q <= '0; prev_q <= '0; older_q <= '0;
            last_peak_q <= '0; peak_valid_q <= 1'b0;
            rate_q <= '0; ivl_q <= '0; oxy_q <= '0;
          end
        end
      end
      if (cmd_i.base) base_q <= XW'(base_sum >> 16);
      if (cmd_i.thr) thr_q <= XW'(thr_sum >> 16);
      if (cmd_i.peak) begin
        if (sts_o.need_rate) begin
          ivl_q <= pdiff[15:0];
        end
        if (is_peak) begin
          last_peak_q <= now_q;
          peak_valid_q <= 1'b1;
        end
        older_q <= prev_q;
        prev_q <= ac_q;
      end
      if (cmd_i.rate) rate_q <= (rate_q == 16'd0) ? rate_cur[15:0] : rate_sum[31:16];
      if (cmd_i.t2_start) begin
        t1_q <= div_quo;
        if (tmo_hit) begin
          rate_q <= '0; oxy_q <= '0; ivl_q <= '0; thr_q <= '0;
          peak_valid_q <= 1'b0;
        end
      end
      if (cmd_i.oxy) oxy_q <= (oxy_q == 15'd0) ? raw[14:0] : oxy_sum[30:16];
      if (cmd_i.out_load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // The sign of the AC term is captured when its division starts.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ir_q <= ir_i; red_q <= red_i; now_q <= time_i;
      used_q <= 1'b0; finger_q <= 1'b0; beat_q <= 1'b0;
    end
    if (cmd_i.check) begin
      used_q <= !sts_o.too_soon;
      finger_q <= !sts_o.too_soon && !sts_o.no_finger;
      ac_q <= '0;
    end
    if (cmd_i.base) ac_q <= $signed({1'b0, x}) - $signed({1'b0, XW'(base_sum >> 16)});
    if (cmd_i.peak) beat_q <= is_peak;
    if (cmd_i.t2_start) t2_neg_q <= ac_q[AW-1];
    if (cmd_i.out_load) begin
      sample_used_o <= used_q;
      finger_present_o <= finger_q;
      beat_o <= beat_q && finger_q;
      heart_rate_o <= finger_q ? rate_q : 16'd0;
      beat_interval_ms_o <= finger_q ? ivl_q : 16'd0;
      oxygen_level_o <= finger_q ? oxy_q : 15'd0;
      dc_level_o <= finger_q ? 26'(base_q) : 26'd0;
      ac_level_o <= finger_q ? 27'(ac_q) : 27'sd0;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule

[src/ppg_pulse_and_oxygen_estimator_unit.sv]
// Each accepted sample word yields one result word; words that update the heart
// rate take the longest path, and words that are too early or find no finger
// skip the arithmetic. A new word is taken only after the result register is
// loaded, later if the output stalls. One shared 48-bit serial divider runs
// two or three divisions per word, none for a skipped word.
// Reset is asynchronous, active low; tracking clears and registers take their defaults.
`include "ppg_pulse_and_oxygen_estimator_unit_defines.svh"
module ppg_pulse_and_oxygen_estimator_unit #(
  parameter int SampleBits   = ppg_pkg::SampleBitsDef,
  parameter int FractionBits = ppg_pkg::FractionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppg_in_if.sink      in_if,
  ppg_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ppg_pkg::AddrBits-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppg_pkg::*;
  logic [15:0] alpha_q, ivl_q, minb_q, maxb_q, tmo_q;
  logic [17:0] fing_q;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic in_ready;
  logic wr;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 16'd655; ivl_q <= 16'd10; fing_q <= 18'd8000;
      minb_q <= 16'd450; maxb_q <= 16'd1500; tmo_q <= 16'd3000;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        REG_DC_ALPHA: alpha_q <= pwdata[15:0];
        REG_INTERVAL: ivl_q <= pwdata[15:0];
        REG_FINGER:   fing_q <= pwdata[17:0];
        REG_MIN_BEAT: minb_q <= pwdata[15:0];
        REG_MAX_BEAT: maxb_q <= pwdata[15:0];
        REG_TIMEOUT:  tmo_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DC_ALPHA: prdata = {16'd0, alpha_q};
      REG_INTERVAL: prdata = {16'd0, ivl_q};
      REG_FINGER:   prdata = {14'd0, fing_q};
      REG_MIN_BEAT: prdata = {16'd0, minb_q};
      REG_MAX_BEAT: prdata = {16'd0, maxb_q};
      REG_TIMEOUT:  prdata = {16'd0, tmo_q};
      default:      prdata = '0;
    endcase
  end

  ppg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_ready),
    .out_busy_i(out_if.valid && !out_if.ready), .sts_i(sts), .cmd_o(cmd)
  );
  assign in_if.ready = in_ready;

  ppg_datapath #(.SampleBits(SampleBits), .FractionBits(FractionBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .ir_i(in_if.ir_sample), .red_i(in_if.red_sample), .time_i(in_if.time_ms),
    .dc_alpha_i(alpha_q), .interval_i(ivl_q), .finger_i(fing_q),
    .min_beat_i(minb_q), .max_beat_i(maxb_q), .timeout_i(tmo_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sample_used_o(out_if.sample_used), .finger_present_o(out_if.finger_present),
    .beat_o(out_if.beat), .heart_rate_o(out_if.heart_rate),
    .beat_interval_ms_o(out_if.beat_interval_ms), .oxygen_level_o(out_if.oxygen_level),
    .dc_level_o(out_if.dc_level), .ac_level_o(out_if.ac_level)
  );

  `PPG_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.base, cmd.thr, cmd.peak, cmd.oxy}))
  `PPG_ASSERT_NEXT(a_out_load, cmd.out_load, out_if.valid)
  `PPG_ASSERT_IMP(a_beat_finger, out_if.valid && out_if.beat, out_if.finger_present)
endmodule
